// ===== rtl/vga_timing_generator_nco_macros.svh =====
// assertion macros for the vga timing generator checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef VGA_TIMING_GENERATOR_NCO_MACROS_SVH
`define VGA_TIMING_GENERATOR_NCO_MACROS_SVH

// same-cycle implication
`define VGAN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vga timing generator check failed");

// next-cycle implication
`define VGAN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vga timing generator check failed");

`endif

// ===== rtl/vgan_pkg.sv =====
// shared types, constants and helpers for the vga timing generator
// no dependencies
`default_nettype none

package vgan_pkg;

  localparam int PHASE_BITS      = 36;
  localparam int COUNT_BITS      = 12;
  localparam int BYTES_PER_PIXEL = 4;

  localparam int CFG_W    = 49;
  localparam int TIMING_W = 49;
  localparam int ACT_W    = 24;
  localparam int ADDR_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [ACT_W-1:0] ACT_MAX = {ACT_W{1'b1}};

  localparam logic [TIMING_W-1:0]   H_TIMING_RST = 49'd1101124862752;
  localparam logic [TIMING_W-1:0]   V_TIMING_RST = 49'd687230288397;
  localparam logic [PHASE_BITS-1:0] NCO_INC_RST  = PHASE_BITS'(64'd8650064134);
  localparam logic [ACT_W-1:0]      FRAME_PIX_RST = 24'd307200;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WADDR = 2'd1,
    FUNC_START = 2'd2,
    FUNC_STOP  = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_H_TIMING  = 3'd0,
    CFG_V_TIMING  = 3'd1,
    CFG_NCO_INC   = 3'd2,
    CFG_FRAME_PIX = 3'd3,
    CFG_IRQ_EN    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                  pos;
    logic [COUNT_BITS-1:0] front;
    logic [COUNT_BITS-1:0] sync;
    logic [COUNT_BITS-1:0] active;
    logic [COUNT_BITS-1:0] total;
  } timing_t;

  typedef struct packed {
    logic in_active;
    logic sync_level;
  } axis_stat_t;

  function automatic timing_t unpack_timing(input logic [TIMING_W-1:0] r);
    timing_t t;
    t.total  = r[11:0];
    t.active = r[23:12];
    t.sync   = r[35:24];
    t.front  = r[47:36];
    t.pos    = r[48];
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vgan_axis.sv =====
// one timing axis: active-area and sync decode for a counter value
// depends on vgan_pkg
`default_nettype none

module vgan_axis (
  input  wire logic [vgan_pkg::COUNT_BITS-1:0] count_i,
  input  wire vgan_pkg::timing_t               timing_i,
  input  wire logic                            run_i,
  output vgan_pkg::axis_stat_t                 stat_o
);

  logic [vgan_pkg::COUNT_BITS:0]   sync_start;
  logic [vgan_pkg::COUNT_BITS+1:0] sync_stop;
  logic                            in_sync;

  assign sync_start = {1'b0, timing_i.active} + {1'b0, timing_i.front};
  assign sync_stop  = {1'b0, sync_start} + {2'b00, timing_i.sync};

  assign in_sync = run_i
                 && ({1'b0, count_i} >= sync_start)
                 && ({2'b00, count_i} < sync_stop);

  assign stat_o.sync_level = (in_sync == timing_i.pos);
  assign stat_o.in_active  = (count_i < timing_i.active);

endmodule

`default_nettype wire

// ===== rtl/vga_timing_generator_nco.sv =====
// vga timing generator with nco pixel clock, top level
// depends on vgan_pkg and vgan_axis
//
// usage:
//   config port: cfg_we_i writes cfg_data_i into register cfg_index_i at the
//   clock edge (0 h_timing, 1 v_timing, 2 nco_increment, 3 frame_pixels,
//   4 irq_enable); other indexes are dropped. write only while idle.
//   input channel: one beat per system tick (func tick) or bus event
//   (write next buffer, start, stop). output channel: one result beat per
//   input beat, carrying the sync levels, strobe, counters, fetch address,
//   frame irq and run flag as they stand after that input.
//   result path: an accepted input beat goes into the input register, then
//   through the update logic into the result register, held back by a stall.
//   throughput: one beat per cycle while results are taken; the phase add and
//   counter update both finish in the single update stage.
//   reset: stopped, counters, phase and bases at zero, registers at defaults.
//   stall: when out_ready_i is low the result holds; one more beat waits in
//   the input register, then in_ready_o drops until the result is taken.
`default_nettype none

module vga_timing_generator_nco (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [vgan_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [vgan_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [vgan_pkg::FUNC_W-1:0]       func_i,
  input  wire logic [vgan_pkg::ADDR_W-1:0]       buffer_address_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   hsync_o,
  output logic                                   vsync_o,
  output logic                                   display_enable_o,
  output logic                                   pixel_strobe_o,
  output logic [vgan_pkg::COUNT_BITS-1:0]        pixel_x_o,
  output logic [vgan_pkg::COUNT_BITS-1:0]        pixel_y_o,
  output logic [vgan_pkg::ADDR_W-1:0]            fetch_address_o,
  output logic                                   frame_irq_o,
  output logic                                   running_o
);

  localparam int PB = vgan_pkg::PHASE_BITS;
  localparam int CB = vgan_pkg::COUNT_BITS;
  localparam int AW = vgan_pkg::ADDR_W;
  localparam int NW = vgan_pkg::ACT_W;

  // config registers
  logic [vgan_pkg::TIMING_W-1:0] h_timing_q, v_timing_q;
  logic [PB-1:0]                 nco_inc_q;
  logic [NW-1:0]                 frame_pix_q;
  logic                          irq_en_q;

  // input register
  logic                  s1_valid_q;
  vgan_pkg::func_e       s1_func_q;
  logic [AW-1:0]         s1_addr_q;

  // block state
  logic [PB-1:0] phase_q, phase_d;
  logic [CB-1:0] h_q, h_d, v_q, v_d;
  logic [NW-1:0] act_q, act_d;
  logic [AW-1:0] base_q, base_d, pend_q, pend_d;
  logic          run_q, run_d;

  // result register
  logic          out_valid_q;
  logic          hsync_q, vsync_q, de_q, strobe_q, irq_q, run_out_q;
  logic [CB-1:0] x_q, y_q;
  logic [AW-1:0] fetch_q;

  logic                 fire;
  vgan_pkg::timing_t    ht, vt;
  logic [PB:0]          phase_sum;
  logic [CB:0]          h_plus, v_plus;
  logic [CB-1:0]        h_next, v_next;
  logic [NW-1:0]        act_inc;
  logic                 old_active;
  logic                 strobe, irq;
  vgan_pkg::axis_stat_t h_stat, v_stat;
  logic [AW-1:0]        fetch_d;

  assign fire       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;

  assign ht = vgan_pkg::unpack_timing(h_timing_q);
  assign vt = vgan_pkg::unpack_timing(v_timing_q);

  assign phase_sum  = {1'b0, phase_q} + {1'b0, nco_inc_q};
  assign h_plus     = {1'b0, h_q} + {{CB{1'b0}}, 1'b1};
  assign v_plus     = {1'b0, v_q} + {{CB{1'b0}}, 1'b1};
  assign h_next     = (h_plus >= {1'b0, ht.total}) ? '0 : h_plus[CB-1:0];
  assign v_next     = (v_plus >= {1'b0, vt.total}) ? '0 : v_plus[CB-1:0];
  assign act_inc    = act_q + {{(NW-1){1'b0}}, 1'b1};
  assign old_active = (h_q < ht.active) && (v_q < vt.active);

  always_comb begin
    phase_d = phase_q;
    h_d     = h_q;
    v_d     = v_q;
    act_d   = act_q;
    base_d  = base_q;
    pend_d  = pend_q;
    run_d   = run_q;
    strobe  = 1'b0;
    irq     = 1'b0;
    if (fire) begin
      unique case (s1_func_q)
        vgan_pkg::FUNC_TICK: begin
          if (run_q) begin
            strobe  = phase_sum[PB];
            phase_d = phase_sum[PB-1:0];
          end
          if (strobe) begin
            if (old_active && (act_q != vgan_pkg::ACT_MAX)) begin
              act_d = act_inc;
              irq   = (act_inc == frame_pix_q) && irq_en_q;
            end
            h_d = h_next;
            if (h_next == '0) begin
              v_d = v_next;
              if (v_next == '0) begin
                base_d = pend_q;
                act_d  = '0;
              end
            end
          end
        end
        vgan_pkg::FUNC_WADDR: begin
          pend_d = s1_addr_q;
        end
        vgan_pkg::FUNC_START: begin
          if (!run_q) begin
            run_d  = 1'b1;
            base_d = pend_q;
            act_d  = '0;
          end
        end
        vgan_pkg::FUNC_STOP: begin
          run_d   = 1'b0;
          phase_d = '0;
          h_d     = '0;
          v_d     = '0;
          act_d   = '0;
        end
        default: begin
          run_d = run_q;
        end
      endcase
    end
  end

  vgan_axis u_h_axis (
    .count_i  (h_d),
    .timing_i (ht),
    .run_i    (run_d),
    .stat_o   (h_stat)
  );

  vgan_axis u_v_axis (
    .count_i  (v_d),
    .timing_i (vt),
    .run_i    (run_d),
    .stat_o   (v_stat)
  );

  assign fetch_d = base_d + AW'(AW'(act_d) * AW'(vgan_pkg::BYTES_PER_PIXEL));

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_timing_q  <= vgan_pkg::H_TIMING_RST;
      v_timing_q  <= vgan_pkg::V_TIMING_RST;
      nco_inc_q   <= vgan_pkg::NCO_INC_RST;
      frame_pix_q <= vgan_pkg::FRAME_PIX_RST;
      irq_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (vgan_pkg::cfg_idx_e'(cfg_index_i))
        vgan_pkg::CFG_H_TIMING:  h_timing_q  <= cfg_data_i[vgan_pkg::TIMING_W-1:0];
        vgan_pkg::CFG_V_TIMING:  v_timing_q  <= cfg_data_i[vgan_pkg::TIMING_W-1:0];
        vgan_pkg::CFG_NCO_INC:   nco_inc_q   <= cfg_data_i[PB-1:0];
        vgan_pkg::CFG_FRAME_PIX: frame_pix_q <= cfg_data_i[NW-1:0];
        vgan_pkg::CFG_IRQ_EN:    irq_en_q    <= cfg_data_i[0];
        default: begin
          irq_en_q <= irq_en_q;
        end
      endcase
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      h_q         <= '0;
      v_q         <= '0;
      act_q       <= '0;
      base_q      <= '0;
      pend_q      <= '0;
      run_q       <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      phase_q <= phase_d;
      h_q     <= h_d;
      v_q     <= v_d;
      act_q   <= act_d;
      base_q  <= base_d;
      pend_q  <= pend_d;
      run_q   <= run_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_func_q <= vgan_pkg::func_e'(func_i);
      s1_addr_q <= buffer_address_i;
    end
    if (fire) begin
      hsync_q   <= h_stat.sync_level;
      vsync_q   <= v_stat.sync_level;
      de_q      <= run_d && h_stat.in_active && v_stat.in_active;
      strobe_q  <= strobe;
      x_q       <= h_d;
      y_q       <= v_d;
      fetch_q   <= fetch_d;
      irq_q     <= irq;
      run_out_q <= run_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hsync_o          = hsync_q;
  assign vsync_o          = vsync_q;
  assign display_enable_o = de_q;
  assign pixel_strobe_o   = strobe_q;
  assign pixel_x_o        = x_q;
  assign pixel_y_o        = y_q;
  assign fetch_address_o  = fetch_q;
  assign frame_irq_o      = irq_q;
  assign running_o        = run_out_q;

endmodule

`default_nettype wire

// ===== rtl/vgan_checker.sv =====
// port-level checks for the vga timing generator, bound to the top level
// depends on vgan_pkg and vga_timing_generator_nco_macros.svh
`default_nettype none

`include "vga_timing_generator_nco_macros.svh"

module vgan_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic                           display_enable_o,
  input wire logic                           pixel_strobe_o,
  input wire logic [vgan_pkg::ADDR_W-1:0]    fetch_address_o,
  input wire logic                           frame_irq_o,
  input wire logic                           running_o
);

  // stalled result beat holds
  `VGAN_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(fetch_address_o))

  // frame done only on a pixel strobe
  `VGAN_ASSERT_IMP(a_irq_strobe, out_valid_o && frame_irq_o, pixel_strobe_o)

  // no display enable while stopped
  `VGAN_ASSERT_IMP(a_de_running, out_valid_o && display_enable_o, running_o)

  // no strobe while stopped
  `VGAN_ASSERT_IMP(a_strobe_running, out_valid_o && pixel_strobe_o, running_o)

endmodule

bind vga_timing_generator_nco vgan_checker u_vgan_checker (.*);

`default_nettype wire
